// ===== sv/pen_pkg.sv =====
`default_nettype none
package pen_pkg;

    localparam int ID_W     = 32;
    localparam int PERIOD_W = 16;
    localparam int DUE_W    = 48;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SERVE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_SERVED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

    localparam logic [DUE_W-1:0] DUE_MAX = {DUE_W{1'b1}};

    typedef logic [ID_W-1:0]     t_id;
    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [DUE_W-1:0]    t_due;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [ACTION_W-1:0] t_action;

    // One table entry as it is held in the entry memory.
    typedef struct packed {
        t_id     id;
        t_period period;
        t_due    due;
    } t_entry;

    // Control from the sequencer to the minimum tracking unit.
    typedef struct packed {
        logic start;   // forget the current best, a new scan begins
        logic valid;   // read data of one entry is present this cycle
    } t_scan_ctl;

endpackage
`default_nettype wire

// ===== sv/periodic_earliest_next_scheduler.sv =====
`default_nettype none
// Periodic client scheduler that serves the client with the earliest due time.
// Input channel (i_in_valid / o_in_stall) carries one item: an action with a
// client id and period. Add appends a client whose first due time is its
// period, serve reports the client with the smallest due time (ties go to the
// smaller id, then to the older slot) and advances its due time by its
// period, saturating at the largest 48-bit value, and clear empties the table.
// The unused action code is taken and produces no result.
// Output channel (o_out_valid / i_out_stall) carries one result item per add,
// serve or clear: the served id (zero unless served) and a status code.
// Add, clear and a serve on an empty table go from acceptance straight to the
// S_DONE state, which moves the result into the output register. A serve on a
// table with entries passes S_SCAN, S_DRAIN, S_WRITE and S_DONE; the scan is shaped
// by the one read port of the entry memory: a shared comparator walks the
// entries one per cycle, then the winner is written back through its write port.
// One item is in work at a time; o_in_stall is high from acceptance until the
// result has moved into the output register. A result waiting under
// i_out_stall does not block the next item, but a second finished result
// waits inside the block until the output register frees up.
// Reset empties the table and drops any pending result; memory contents are
// left as they are and are never read before an add writes them.
module periodic_earliest_next_scheduler #(
    parameter int MAX_CLIENTS = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire pen_pkg::t_action i_action,
    input  wire pen_pkg::t_id     i_client_id,
    input  wire pen_pkg::t_period i_client_period,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output pen_pkg::t_id          o_served_id,
    output pen_pkg::t_status      o_status
);
    import pen_pkg::*;

    localparam int AW = $clog2(MAX_CLIENTS);
    localparam int CW = $clog2(MAX_CLIENTS + 1);
    localparam int EW = $bits(t_entry);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic          r_rd_valid, n_rd_valid;
    logic [AW-1:0] r_rd_slot;
    t_id           r_res_id, n_res_id;
    t_status       r_res_status, n_res_status;
    logic          r_out_valid, n_out_valid;
    t_id           r_served_id;
    t_status       r_status;

    logic          in_acc;
    logic          out_free;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic          ram_re;
    t_entry        ram_rdata;
    logic [EW-1:0] ram_rdata_raw;
    t_scan_ctl     scan_ctl;
    t_entry        best;
    logic [AW-1:0] best_slot;
    logic [DUE_W:0] due_sum;
    t_entry        new_entry;

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // The advance of the winner's due time, one bit wider so that an overflow can saturate.
    always_comb begin
        due_sum = {1'b0, best.due} + {{(DUE_W + 1 - PERIOD_W){1'b0}}, best.period};
    end

    always_comb begin
        new_entry.id     = i_client_id;
        new_entry.period = i_client_period;
        new_entry.due    = {{(DUE_W - PERIOD_W){1'b0}}, i_client_period};
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_rd_valid   = 1'b0;
        n_res_id     = r_res_id;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        ram_we       = 1'b0;
        ram_waddr    = r_count[AW-1:0];
        ram_wdata    = new_entry;
        ram_re       = 1'b0;
        scan_ctl     = '{start: 1'b0, valid: r_rd_valid};

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_action)
                        ACT_ADD: begin
                            n_res_id = '0;
                            n_state  = S_DONE;
                            if (r_count >= CW'(MAX_CLIENTS)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                ram_we       = 1'b1;
                                n_count      = r_count + CW'(1);
                                n_res_status = ST_ADDED;
                            end
                        end
                        ACT_SERVE: begin
                            n_res_id = '0;
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                scan_ctl.start = 1'b1;
                                n_rd_idx       = '0;
                                n_state        = S_SCAN;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count      = '0;
                            n_res_id     = '0;
                            n_res_status = ST_CLEARED;
                            n_state      = S_DONE;
                        end
                        ACT_UNUSED: begin
                            n_state = S_IDLE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                ram_re     = 1'b1;
                n_rd_valid = 1'b1;
                if (r_rd_idx == r_count - CW'(1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + CW'(1);
                end
            end
            S_DRAIN: begin
                // The last entry's read data is compared in this cycle.
                n_state = S_WRITE;
            end
            S_WRITE: begin
                ram_we        = 1'b1;
                ram_waddr     = best_slot;
                ram_wdata     = best;
                ram_wdata.due = due_sum[DUE_W] ? DUE_MAX : due_sum[DUE_W-1:0];
                n_res_id      = best.id;
                n_res_status  = ST_SERVED;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_rd_slot    <= r_rd_idx[AW-1:0];
        r_res_id     <= n_res_id;
        r_res_status <= n_res_status;
        if (r_state == S_DONE && out_free) begin
            r_served_id <= r_res_id;
            r_status    <= r_res_status;
        end
    end

    pen_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_CLIENTS)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = t_entry'(ram_rdata_raw);

    pen_best #(
        .ADDR_W (AW)
    ) u_best (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_entry     (ram_rdata),
        .i_slot      (r_rd_slot),
        .o_best      (best),
        .o_best_slot (best_slot)
    );

    assign o_out_valid = r_out_valid;
    assign o_served_id = r_served_id;
    assign o_status    = r_status;

endmodule
`default_nettype wire

// ===== sv/pen_ram.sv =====
`default_nettype none
module pen_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/pen_best.sv =====
`default_nettype none
module pen_best #(
    parameter int ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pen_pkg::t_scan_ctl i_ctl,
    input  wire pen_pkg::t_entry   i_entry,
    input  wire logic [ADDR_W-1:0] i_slot,
    output pen_pkg::t_entry        o_best,
    output logic      [ADDR_W-1:0] o_best_slot
);
    import pen_pkg::*;

    logic   r_have;
    t_entry r_best;
    logic [ADDR_W-1:0] r_best_slot;
    logic   take;

    // Strictly earlier due time, or equal due time and smaller id. A full tie
    // keeps the earlier slot, since slots are scanned in ascending order.
    always_comb begin
        take = !r_have
            || (i_entry.due < r_best.due)
            || ((i_entry.due == r_best.due) && (i_entry.id < r_best.id));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.start) begin
            r_have <= 1'b0;
        end else if (i_ctl.valid) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.start && i_ctl.valid && take) begin
            r_best      <= i_entry;
            r_best_slot <= i_slot;
        end
    end

    assign o_best      = r_best;
    assign o_best_slot = r_best_slot;

endmodule
`default_nettype wire

// ===== sv/pen_chk.sv =====
`default_nettype none
module pen_chk (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire pen_pkg::t_action i_action,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire pen_pkg::t_id     o_served_id,
    input wire pen_pkg::t_status o_status
);
    import pen_pkg::*;

    // Reset drops any pending result.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A result waiting under stall is not withdrawn.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("stalled result changed or vanished");

    // Only a served result carries an id.
    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_SERVED) |-> o_served_id == '0)
        else $error("nonzero id on a result that is not served");

    // An item that produces a result keeps the input busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_action != ACT_UNUSED) |=> o_in_stall)
        else $error("input ready again before the result was produced");

endmodule

bind periodic_earliest_next_scheduler pen_chk u_pen_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_served_id (o_served_id),
    .o_status    (o_status)
);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;
    import pen_pkg::*;

    // The table depth matches the instance below. The predictor keeps a table of the
    // same size.
    localparam int TABLE_DEPTH  = 64;
    // The tail must cover a serve on a full table, which scans the whole depth. Give some slack beyond that.
    localparam int TAIL_CYCLES  = TABLE_DEPTH + 8;
    // The limit is set well above the slowest correct run, in which every serve scans
    // a full table and both sides idle heavily.
    localparam int RUN_LIMIT_NS = 2_000_000;

    // One result item as the output channel carries it.
    typedef struct packed {
        t_id     served_id;
        t_status status;
    } t_outcome;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_stall;
    t_action i_action;
    t_id     i_client_id;
    t_period i_client_period;
    logic    o_out_valid;
    logic    i_out_stall;
    t_id     o_served_id;
    t_status o_status;

    // The predictor's copy of the client table.
    t_id         table_ids     [TABLE_DEPTH];
    t_period     table_periods [TABLE_DEPTH];
    t_due        table_due     [TABLE_DEPTH];
    int unsigned table_fill;

    // Results are predicted at input acceptance and retired in order at the output.
    t_outcome    awaited_results[$];
    t_outcome    head_result;
    int unsigned fail_count = 0;

    // Idle chances in percent per cycle. Each phase of the run sets them.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    periodic_earliest_next_scheduler #(
        .MAX_CLIENTS(TABLE_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_client_id    (i_client_id),
        .i_client_period(i_client_period),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_served_id    (o_served_id),
        .o_status       (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one accepted item to the predicted table and queue the result that it causes.
    // Ties on due time go to the smaller id. The strict compare keeps the lower slot
    // when both the due time and the id are equal.
    function automatic void predict_schedule(t_action act, t_id id, t_period period);
        t_outcome outcome;
        int       best;
        t_due     due;
        outcome.served_id = '0;
        case (act)
            ACT_ADD: begin
                if (table_fill >= TABLE_DEPTH) begin
                    outcome.status = ST_FULL;
                end else begin
                    table_ids[table_fill]     = id;
                    table_periods[table_fill] = period;
                    table_due[table_fill]     = t_due'(period);
                    table_fill++;
                    outcome.status = ST_ADDED;
                end
            end
            ACT_SERVE: begin
                if (table_fill == 0) begin
                    outcome.status = ST_EMPTY;
                end else begin
                    best = 0;
                    for (int i = 1; i < table_fill; i++) begin
                        if (table_due[i] < table_due[best] ||
                            (table_due[i] == table_due[best] && table_ids[i] < table_ids[best]))
                            best = i;
                    end
                    outcome.served_id = table_ids[best];
                    due = table_due[best];
                    // The due time saturates at its largest value.
                    if (DUE_MAX - due < t_due'(table_periods[best]))
                        due = DUE_MAX;
                    else
                        due = due + t_due'(table_periods[best]);
                    table_due[best] = due;
                    outcome.status = ST_SERVED;
                end
            end
            ACT_CLEAR: begin
                table_fill = 0;
                outcome.status = ST_CLEARED;
            end
            default: begin
                // The unused action code is taken and causes nothing.
                return;
            end
        endcase
        awaited_results.push_back(outcome);
    endfunction

    // Offer one item and wait for it to be accepted.
    // After acceptance valid stays high, so that the next call can follow in the
    // same step without a drop. Idle cycles lower valid first, one step earlier.
    task automatic send_item(t_action act, t_id id, t_period period);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_client_id     <= id;
        i_client_period <= period;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_schedule(act, id, period);
    endtask

    // Periods lean toward small values so that due times collide often. Zero, one and
    // the largest period also appear, along with the full range.
    function automatic t_period pick_period();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        else if (roll < 10)
            return '1;
        else if (roll < 50)
            return t_period'($urandom_range(8, 1));
        else
            return t_period'($urandom_range(65535, 1));
    endfunction

    // Extreme field values, every action, and the special cases: a serve on an empty
    // table, a zero period, ties on due time, ties on both due time and id, the unused
    // code, and a clear.
    task automatic test_directed_cases();
        send_item(ACT_SERVE, '1, '1);
        send_item(ACT_CLEAR, '0, '0);
        send_item(ACT_ADD, '0, t_period'(1));
        send_item(ACT_ADD, '1, '1);
        send_item(ACT_ADD, t_id'(5), '0);
        send_item(ACT_SERVE, '0, '0);
        send_item(ACT_SERVE, '1, '1);
        send_item(ACT_ADD, t_id'(7), t_period'(2));
        send_item(ACT_ADD, t_id'(7), t_period'(2));
        send_item(ACT_ADD, t_id'(3), t_period'(1));
        repeat (6) send_item(ACT_SERVE, t_id'($urandom), t_period'($urandom));
        send_item(ACT_UNUSED, '1, '1);
        send_item(ACT_UNUSED, '0, '0);
        send_item(ACT_CLEAR, '1, '1);
        send_item(ACT_SERVE, '0, '0);
        send_item(ACT_ADD, t_id'(9), t_period'(3));
        send_item(ACT_SERVE, '0, '0);
    endtask

    // Fill the table to the last slot and try to add past it. Then serve across a
    // full table, with a small id pool so that ties are common.
    task automatic test_table_full();
        send_item(ACT_CLEAR, t_id'($urandom), t_period'($urandom));
        repeat (TABLE_DEPTH)
            send_item(ACT_ADD, t_id'($urandom_range(15)), t_period'($urandom_range(16, 1)));
        send_item(ACT_ADD, '1, '1);
        send_item(ACT_ADD, t_id'($urandom), pick_period());
        repeat (30) send_item(ACT_SERVE, t_id'($urandom), t_period'($urandom));
        send_item(ACT_ADD, t_id'($urandom), pick_period());
        send_item(ACT_CLEAR, t_id'($urandom), t_period'($urandom));
    endtask

    // Traffic is mostly adds and serves. Occasional clears keep the table small most
    // of the time, and unused codes are mixed in. The unused codes do not count
    // toward the item number.
    task automatic test_random_traffic(int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        t_id         id;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            id   = ($urandom_range(1) == 1) ? t_id'($urandom_range(7)) : t_id'($urandom);
            if (pick < 42) begin
                send_item(ACT_ADD, id, pick_period());
                sent++;
            end else if (pick < 92) begin
                send_item(ACT_SERVE, id, t_period'($urandom));
                sent++;
            end else if (pick < 96) begin
                send_item(ACT_CLEAR, id, t_period'($urandom));
                sent++;
            end else begin
                send_item(ACT_UNUSED, id, t_period'($urandom));
            end
        end
    endtask

    // The receiver stalls at random, with the chance that the current phase sets.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Each accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: served_id %0h status %0d", o_served_id, o_status);
                fail_count++;
            end else begin
                head_result = awaited_results.pop_front();
                if (o_served_id !== head_result.served_id) begin
                    $error("served_id: expected %0h, got %0h",
                           head_result.served_id, o_served_id);
                    fail_count++;
                end
                if (o_status !== head_result.status) begin
                    $error("status: expected %0d, got %0d", head_result.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    // Saturation of the due time is in the predictor. The stimulus cannot reach it:
    // it takes about 2^32 serves of one client, which is far beyond this run.
    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_action        <= ACT_ADD;
        i_client_id     <= '0;
        i_client_period <= '0;
        i_out_stall     <= 1'b0;
        table_fill      = 0;
        send_idle_pct   = 9;
        recv_idle_pct   = 86;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_table_full();
        test_random_traffic(500);

        send_idle_pct = 86;
        recv_idle_pct = 9;
        test_random_traffic(450);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(400);

        // Close the input. Wait for every predicted result, then wait out the latency.
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && awaited_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
